// ===== rtl/hfd_pkg.sv =====
// shared types, constants and the hex digit decode for the hex frame descrambler
// no dependencies; imported by every module of the block
package hfd_pkg;

  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOWER_F = 8'h66;  // 'f'
  localparam logic [7:0] FIRST_MASK = 8'h43;

  localparam logic [15:0] HEADER_CHARS = 16'd4;
  localparam logic [15:0] CAP_RESET    = 16'hFFFF;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_SHORT_HDR  = 2'd1;
  localparam logic [1:0] ST_OVER_CAP   = 2'd2;
  localparam logic [1:0] ST_SHORT_TEXT = 2'd3;

  typedef struct packed {
    logic [7:0]  ch;
    logic        first;
    logic [15:0] text_length;
  } hfd_in_t;

  typedef struct packed {
    logic        is_data;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] result_length;
    logic [1:0]  status;
  } hfd_out_t;

  // anything outside 0-9 and a-f decodes to zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      v = c - CH_LOWER_A + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/hfd_engine.sv =====
// frame parser and descrambler state: header count, seed, previous cipher byte
// depends on hfd_pkg; result is combinational from the held state and one character
module hfd_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  hfd_pkg::hfd_in_t  item,
  input  logic [15:0]       capacity,
  output logic              emit,
  output hfd_pkg::hfd_out_t res
);
  import hfd_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_BODY} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] header_value_r, header_value_nxt;
  logic [1:0]  char_count_r, char_count_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic        nibble_phase_r, nibble_phase_nxt;
  logic [7:0]  seed_byte_r, seed_byte_nxt;
  logic [7:0]  prev_cipher_r, prev_cipher_nxt;
  logic [15:0] text_len_held_r, text_len_held_nxt;
  logic        first_pending_r, first_pending_nxt;

  logic [3:0]  d;
  logic [15:0] hv;
  logic [14:0] avail;
  logic [7:0]  cbyte;
  logic [15:0] bl_dec;

  always_comb begin
    d                 = hex_nibble(item.ch);
    hv                = 16'd0;
    avail             = 15'd0;
    cbyte             = 8'd0;
    bl_dec            = 16'd0;
    emit              = 1'b0;
    res               = '0;
    phase_nxt         = phase_r;
    header_value_nxt  = header_value_r;
    char_count_nxt    = char_count_r;
    bytes_left_nxt    = bytes_left_r;
    high_nibble_nxt   = high_nibble_r;
    nibble_phase_nxt  = nibble_phase_r;
    seed_byte_nxt     = seed_byte_r;
    prev_cipher_nxt   = prev_cipher_r;
    text_len_held_nxt = text_len_held_r;
    first_pending_nxt = first_pending_r;

    // start of message aborts whatever was in progress
    if (item.first) begin
      text_len_held_nxt = item.text_length;
      header_value_nxt  = 16'd0;
      char_count_nxt    = 2'd0;
      bytes_left_nxt    = 16'd0;
      nibble_phase_nxt  = 1'b0;
      high_nibble_nxt   = 4'd0;
      first_pending_nxt = 1'b0;
      if (item.text_length < HEADER_CHARS) begin
        phase_nxt  = PH_IDLE;
        emit       = 1'b1;
        res.last   = 1'b1;
        res.status = ST_SHORT_HDR;
      end else begin
        phase_nxt = PH_HEADER;
      end
    end

    if (!emit) begin
      case (phase_nxt)
        PH_HEADER: begin
          hv               = {header_value_nxt[11:0], d};
          header_value_nxt = hv;
          avail            = 15'((text_len_held_nxt - HEADER_CHARS) >> 1);
          if (char_count_nxt != 2'd3) begin
            char_count_nxt = char_count_nxt + 2'd1;
          end else begin
            char_count_nxt = 2'd0;
            if (hv > capacity) begin
              emit       = 1'b1;
              res.last   = 1'b1;
              res.status = ST_OVER_CAP;
            end else if (hv > {1'b0, avail}) begin
              emit       = 1'b1;
              res.last   = 1'b1;
              res.status = ST_SHORT_TEXT;
            end else if (hv == 16'd0) begin
              emit       = 1'b1;
              res.last   = 1'b1;
              res.status = ST_OK;
            end else begin
              phase_nxt        = PH_BODY;
              bytes_left_nxt   = hv;
              nibble_phase_nxt = 1'b0;
            end
          end
        end
        PH_BODY: begin
          if (!nibble_phase_nxt) begin
            high_nibble_nxt  = d;
            nibble_phase_nxt = 1'b1;
          end else begin
            nibble_phase_nxt = 1'b0;
            cbyte            = {high_nibble_nxt, d};
            bl_dec           = bytes_left_nxt - 16'd1;
            bytes_left_nxt   = bl_dec;
            if (bytes_left_r == header_value_r) begin
              // seed byte
              seed_byte_nxt     = cbyte;
              prev_cipher_nxt   = cbyte;
              first_pending_nxt = 1'b1;
              if (bl_dec == 16'd0) begin
                emit     = 1'b1;
                res.last = 1'b1;
              end
            end else begin
              emit          = 1'b1;
              res.is_data   = 1'b1;
              res.data_byte = first_pending_nxt ? (cbyte ^ (seed_byte_nxt | FIRST_MASK))
                                                : (cbyte ^ prev_cipher_nxt ^ seed_byte_nxt);
              prev_cipher_nxt   = cbyte;
              first_pending_nxt = 1'b0;
              if (bl_dec == 16'd0) begin
                res.last          = 1'b1;
                res.result_length = header_value_nxt - 16'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (emit && res.last) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      header_value_r  <= 16'd0;
      char_count_r    <= 2'd0;
      bytes_left_r    <= 16'd0;
      high_nibble_r   <= 4'd0;
      nibble_phase_r  <= 1'b0;
      seed_byte_r     <= 8'd0;
      prev_cipher_r   <= 8'd0;
      text_len_held_r <= 16'd0;
      first_pending_r <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      header_value_r  <= header_value_nxt;
      char_count_r    <= char_count_nxt;
      bytes_left_r    <= bytes_left_nxt;
      high_nibble_r   <= high_nibble_nxt;
      nibble_phase_r  <= nibble_phase_nxt;
      seed_byte_r     <= seed_byte_nxt;
      prev_cipher_r   <= prev_cipher_nxt;
      text_len_held_r <= text_len_held_nxt;
      first_pending_r <= first_pending_nxt;
    end
  end

endmodule

// ===== rtl/hex_frame_descrambler_core.sv =====
// top level of the hex frame descrambler: input register, engine, result register
// depends on hfd_pkg and hfd_engine
//
// Takes one ASCII character per cycle unless backpressure holds it. A message
// opens with four lower-case hex digits giving a byte count; the digit pairs after
// it are a seed byte followed by scrambled bytes, and each scrambled byte produces
// one plain-byte result. Header errors and the end of a message produce a single
// result flagged last with a status code. A character is processed once it sits in
// the input register and the result register can advance, and its result is
// registered at the end of that cycle; the input register and the result register
// keep one character per cycle flowing under backpressure until both are full. The
// capacity register may only be written while no message character is in flight.
module hex_frame_descrambler_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hfd_pkg::hfd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hfd_pkg::hfd_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import hfd_pkg::*;

  logic        in_valid_r;
  hfd_in_t     in_data_r;
  logic        out_valid_r;
  hfd_out_t    out_data_r;
  logic [15:0] capacity_r;
  logic        advance;
  logic        emit;
  hfd_out_t    res;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  hfd_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_valid_r && advance),
    .item     (in_data_r),
    .capacity (capacity_r),
    .emit     (emit),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      capacity_r  <= CAP_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r && emit;
      end
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (advance && in_valid_r && emit) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== rtl/hfd_checker.sv =====
// port-level checks on the hex frame descrambler results
// depends on hfd_pkg; bound to hex_frame_descrambler_core below
module hfd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input hfd_pkg::hfd_out_t out_data
);
  import hfd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_data |-> out_data.data_byte == 8'd0 && out_data.last)
    else $error("non-data result carries a byte or is not final");

  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |->
      out_data.result_length == 16'd0 && out_data.status == ST_OK)
    else $error("mid-frame result with length or status");

  a_error_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.last && !out_data.is_data && out_data.result_length == 16'd0)
    else $error("error result malformed");

endmodule

bind hex_frame_descrambler_core hfd_checker u_hfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
